@@ rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the bright pixel centroid block: the pixel
// and result payloads, the per-frame sums record and the saturation limits.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int INTEN_W  = 8;
  localparam int COORD_W  = 10;
  localparam int COUNT_W  = 21;
  localparam int SUM_W    = 30;
  localparam int CENT_W   = 18;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 21'd2097151;
  localparam logic [SUM_W-1:0]   SUM_MAX      = 30'd1073741823;
  localparam logic [CENT_W-1:0]  CENT_MAX     = 18'd262143;
  localparam logic [INTEN_W-1:0] THRESH_RESET = 8'd125;

  // Frame records held between the accumulator and the divider.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [INTEN_W-1:0] intensity;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               frame_end;
  } pixel_in_t;

  typedef struct packed {
    logic [CENT_W-1:0]  centroid_col_q8;
    logic [CENT_W-1:0]  centroid_row_q8;
    logic [COUNT_W-1:0] bright_count;
    logic               none_found;
  } centroid_out_t;

  typedef struct packed {
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [COUNT_W-1:0] count;
  } frame_sums_t;

endpackage

@@ rtl/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// Pixel side: thresholds each pixel, accumulates the bright count and the
// column and row sums with saturation, and hands the totals of a finished
// frame to the queue.
// ----------------------------------------------------------------------------
module bpc_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bpc_pkg::INTEN_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bpc_pkg::pixel_in_t            in_data,
  output logic                          push_o,
  output bpc_pkg::frame_sums_t          push_data_o,
  input  logic                          full_i
);

  logic [bpc_pkg::INTEN_W-1:0] thresh_r;
  logic [bpc_pkg::COUNT_W-1:0] count_acc_r, count_acc_nxt;
  logic [bpc_pkg::SUM_W-1:0]   col_sum_r, col_sum_nxt;
  logic [bpc_pkg::SUM_W-1:0]   row_sum_r, row_sum_nxt;

  logic                        in_fire;
  logic                        in_bounds;
  logic                        bright;
  logic [bpc_pkg::SUM_W:0]     col_add;
  logic [bpc_pkg::SUM_W:0]     row_add;
  logic [bpc_pkg::COUNT_W-1:0] count_upd;
  logic [bpc_pkg::SUM_W-1:0]   col_upd;
  logic [bpc_pkg::SUM_W-1:0]   row_upd;

  // Only a frame-closing pixel needs a queue slot.
  assign in_stall = full_i & in_data.frame_end;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    in_bounds = (32'(in_data.pixel_col) < MAX_COLS) && (32'(in_data.pixel_row) < MAX_ROWS);
    bright    = in_bounds && (in_data.intensity > thresh_r);
    col_add   = {1'b0, col_sum_r} + (bpc_pkg::SUM_W + 1)'(in_data.pixel_col);
    row_add   = {1'b0, row_sum_r} + (bpc_pkg::SUM_W + 1)'(in_data.pixel_row);

    count_upd = count_acc_r;
    col_upd   = col_sum_r;
    row_upd   = row_sum_r;
    if (bright) begin
      if (count_acc_r < bpc_pkg::COUNT_MAX) begin
        count_upd = count_acc_r + 1'b1;
      end
      col_upd = (col_add > (bpc_pkg::SUM_W + 1)'(bpc_pkg::SUM_MAX)) ?
                bpc_pkg::SUM_MAX : col_add[bpc_pkg::SUM_W-1:0];
      row_upd = (row_add > (bpc_pkg::SUM_W + 1)'(bpc_pkg::SUM_MAX)) ?
                bpc_pkg::SUM_MAX : row_add[bpc_pkg::SUM_W-1:0];
    end

    push_o              = in_fire & in_data.frame_end;
    push_data_o.col_sum = col_upd;
    push_data_o.row_sum = row_upd;
    push_data_o.count   = count_upd;

    count_acc_nxt = count_acc_r;
    col_sum_nxt   = col_sum_r;
    row_sum_nxt   = row_sum_r;
    if (in_fire) begin
      if (in_data.frame_end) begin
        count_acc_nxt = '0;
        col_sum_nxt   = '0;
        row_sum_nxt   = '0;
      end else begin
        count_acc_nxt = count_upd;
        col_sum_nxt   = col_upd;
        row_sum_nxt   = row_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= bpc_pkg::THRESH_RESET;
      count_acc_r <= '0;
      col_sum_r   <= '0;
      row_sum_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      count_acc_r <= count_acc_nxt;
      col_sum_r   <= col_sum_nxt;
      row_sum_r   <= row_sum_nxt;
    end
  end

  // A closed frame must leave the accumulators empty for the next one.
  ast_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.frame_end) |=>
      (count_acc_r == '0 && col_sum_r == '0 && row_sum_r == '0))
    else $error("accumulators not cleared after frame end");

endmodule

@@ rtl/bpc_queue.sv @@
// ----------------------------------------------------------------------------
// bpc_queue
// Short FIFO of finished frame totals between the accumulator and the
// divider, so that either side can wait without holding up the other.
// ----------------------------------------------------------------------------
module bpc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  bpc_pkg::frame_sums_t  push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output bpc_pkg::frame_sums_t  pop_data_o,
  output logic                  empty_o
);

  bpc_pkg::frame_sums_t        entry_r [bpc_pkg::QDEPTH];
  logic [bpc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bpc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bpc_pkg::QCNT_W-1:0]  fill_r, fill_nxt;

  assign full_o     = (fill_r == bpc_pkg::QCNT_W'(bpc_pkg::QDEPTH));
  assign empty_o    = (fill_r == '0);
  assign pop_data_o = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == bpc_pkg::QPTR_W'(bpc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == bpc_pkg::QPTR_W'(bpc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r;
    if (push_i && !pop_i) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

  ast_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("frame queue written while full");

  ast_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("frame queue read while empty");

endmodule

@@ rtl/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back
// Result side: takes one frame's totals from the queue, divides both sums
// by the count with a radix-2 restoring divider (one quotient bit per cycle
// for column and row together), saturates and registers the result.
// ----------------------------------------------------------------------------
module bpc_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   pop_o,
  input  bpc_pkg::frame_sums_t   pop_data_i,
  input  logic                   empty_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bpc_pkg::centroid_out_t out_data
);

  localparam int DW = bpc_pkg::SUM_W + FRAC_BITS;
  localparam int SW = $clog2(DW);
  localparam int RW = bpc_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } back_state_t;

  back_state_t           state_r, state_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  logic [RW-1:0]         den_r, den_nxt;
  logic [RW-1:0]         rem_col_r, rem_col_nxt;
  logic [RW-1:0]         rem_row_r, rem_row_nxt;
  logic [DW-1:0]         num_col_r, num_col_nxt;
  logic [DW-1:0]         num_row_r, num_row_nxt;
  logic                  none_r, none_nxt;
  logic                  out_valid_r, out_valid_nxt;
  bpc_pkg::centroid_out_t out_data_r, out_data_nxt;

  logic [RW:0]           trial_col, trial_row;
  logic [RW:0]           diff_col, diff_row;
  logic                  ge_col, ge_row;
  logic                  out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    trial_col = {rem_col_r, num_col_r[DW-1]};
    trial_row = {rem_row_r, num_row_r[DW-1]};
    diff_col  = trial_col - {1'b0, den_r};
    diff_row  = trial_row - {1'b0, den_r};
    ge_col    = trial_col >= {1'b0, den_r};
    ge_row    = trial_row >= {1'b0, den_r};

    state_nxt     = state_r;
    step_nxt      = step_r;
    den_nxt       = den_r;
    rem_col_nxt   = rem_col_r;
    rem_row_nxt   = rem_row_r;
    num_col_nxt   = num_col_r;
    num_row_nxt   = num_row_r;
    none_nxt      = none_r;
    pop_o         = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o       = 1'b1;
          den_nxt     = pop_data_i.count;
          rem_col_nxt = '0;
          rem_row_nxt = '0;
          step_nxt    = '0;
          none_nxt    = (pop_data_i.count == '0);
          if (pop_data_i.count == '0) begin
            // Nothing bright: report zero centroids without dividing.
            num_col_nxt = '0;
            num_row_nxt = '0;
            state_nxt   = ST_HOLD;
          end else begin
            num_col_nxt = DW'(pop_data_i.col_sum) << FRAC_BITS;
            num_row_nxt = DW'(pop_data_i.row_sum) << FRAC_BITS;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // Quotient bits shift into the low end as numerator bits leave the top.
        rem_col_nxt = ge_col ? diff_col[RW-1:0] : trial_col[RW-1:0];
        rem_row_nxt = ge_row ? diff_row[RW-1:0] : trial_row[RW-1:0];
        num_col_nxt = {num_col_r[DW-2:0], ge_col};
        num_row_nxt = {num_row_r[DW-2:0], ge_row};
        step_nxt    = step_r + 1'b1;
        if (step_r == SW'(DW - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.centroid_col_q8 = (64'(num_col_r) > 64'(bpc_pkg::CENT_MAX)) ?
                                         bpc_pkg::CENT_MAX : bpc_pkg::CENT_W'(num_col_r);
          out_data_nxt.centroid_row_q8 = (64'(num_row_r) > 64'(bpc_pkg::CENT_MAX)) ?
                                         bpc_pkg::CENT_MAX : bpc_pkg::CENT_W'(num_row_r);
          out_data_nxt.bright_count    = den_r;
          out_data_nxt.none_found      = none_r;
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    den_r      <= den_nxt;
    rem_col_r  <= rem_col_nxt;
    rem_row_r  <= rem_row_nxt;
    num_col_r  <= num_col_nxt;
    num_row_r  <= num_row_nxt;
    none_r     <= none_nxt;
    out_data_r <= out_data_nxt;
  end

  ast_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_col_r < den_r && rem_row_r < den_r))
    else $error("divider remainder not below divisor");

  ast_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.none_found) |->
      (out_data_r.centroid_col_q8 == '0 && out_data_r.centroid_row_q8 == '0 &&
       out_data_r.bright_count == '0))
    else $error("empty frame result carries nonzero fields");

endmodule

@@ rtl/bright_pixel_centroid.sv @@
// ----------------------------------------------------------------------------
// bright_pixel_centroid
// Thresholded centroid of the bright pixels of each frame, reported as
// unsigned fixed point with FRAC_BITS fraction bits, plus the bright count.
//
//   Channel  Ports                        Direction  Transfer
//   pixel    in_valid/in_stall/in_data    input      valid & !stall
//   result   out_valid/out_stall/out_data output     valid & !stall
//   config   cfg_wr_en/cfg_wr_data        input      write enable high
//
// Pixels are taken one per clock; only a frame-end pixel stalls, and only
// while both queue slots hold frames waiting for the divider.
// Each frame result is divided one quotient bit per cycle, and the divider
// starts no frame before the last is done, so short frames back up the queue.
// A result waits in the output register while the next frame is divided.
// Reset is synchronous: threshold 125, accumulators and queue empty.
// ----------------------------------------------------------------------------
module bright_pixel_centroid #(
  parameter int MAX_COLS  = 1024,
  parameter int MAX_ROWS  = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bpc_pkg::INTEN_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bpc_pkg::pixel_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bpc_pkg::centroid_out_t      out_data
);

  logic                 push;
  bpc_pkg::frame_sums_t push_data;
  logic                 q_full;
  logic                 pop;
  bpc_pkg::frame_sums_t pop_data;
  logic                 q_empty;

  bpc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (q_full)
  );

  bpc_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  bpc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .empty_i    (q_empty),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ verif/bright_pixel_centroid_tb.sv @@
// ----------------------------------------------------------------------------
// bright_pixel_centroid_tb
// Self-checking bench for the bright pixel centroid block. Pixel frames are
// streamed in, a behavioral copy of the accumulate-and-divide logic predicts
// each frame result, and every result transfer is checked field by field.
// Directed frames cover the threshold edges and truncation, and random raster
// frames and scattered noise run under several back-pressure profiles.
// ----------------------------------------------------------------------------
module bright_pixel_centroid_tb;

  localparam int FRAME_COLS   = 1024;
  localparam int FRAME_ROWS   = 1024;
  localparam int Q_FRAC       = 8;
  localparam int SETTLE_CYCLES = 64;
  localparam int END_CYCLES   = 100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PIX_W        = $bits(bpc_pkg::pixel_in_t);

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [bpc_pkg::INTEN_W-1:0] cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  bpc_pkg::pixel_in_t     in_data;
  logic          out_valid;
  logic          out_stall;
  bpc_pkg::centroid_out_t out_data;

  // Behavioral copy of the block state.
  logic [bpc_pkg::INTEN_W-1:0] thresh_now;
  logic [bpc_pkg::COUNT_W-1:0] bright_acc;
  logic [bpc_pkg::SUM_W-1:0]   col_acc;
  logic [bpc_pkg::SUM_W-1:0]   row_acc;

  bpc_pkg::centroid_out_t centroid_q[$];
  bpc_pkg::centroid_out_t oldest_res;
  int            error_count;
  int            pixels_sent;
  int            send_gap_pct;
  int            recv_stall_pct;
  int unsigned   cycle_count;

  bright_pixel_centroid #(
    .MAX_COLS (FRAME_COLS),
    .MAX_ROWS (FRAME_ROWS),
    .FRAC_BITS(Q_FRAC)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bright_pixel_centroid] ERROR");
      $finish;
    end
  end

  function automatic logic [bpc_pkg::SUM_W-1:0] sum_add_sat(
      input logic [bpc_pkg::SUM_W-1:0] acc, input logic [bpc_pkg::COORD_W-1:0] v);
    logic [bpc_pkg::SUM_W:0] s;
    s = {1'b0, acc} + (bpc_pkg::SUM_W + 1)'(v);
    return (s > (bpc_pkg::SUM_W + 1)'(bpc_pkg::SUM_MAX)) ?
           bpc_pkg::SUM_MAX : s[bpc_pkg::SUM_W-1:0];
  endfunction

  // Truncating fixed-point mean, clipped to the centroid field width.
  function automatic logic [bpc_pkg::CENT_W-1:0] mean_q8(
      input logic [bpc_pkg::SUM_W-1:0] sum, input logic [bpc_pkg::COUNT_W-1:0] cnt);
    logic [bpc_pkg::SUM_W+Q_FRAC-1:0] q;
    q = {sum, {Q_FRAC{1'b0}}} / (bpc_pkg::SUM_W + Q_FRAC)'(cnt);
    return (q > (bpc_pkg::SUM_W + Q_FRAC)'(bpc_pkg::CENT_MAX)) ?
           bpc_pkg::CENT_MAX : q[bpc_pkg::CENT_W-1:0];
  endfunction

  task automatic account_pixel(input bpc_pkg::pixel_in_t px);
    bpc_pkg::centroid_out_t res;
    if (32'(px.pixel_col) < FRAME_COLS && 32'(px.pixel_row) < FRAME_ROWS &&
        px.intensity > thresh_now) begin
      if (bright_acc < bpc_pkg::COUNT_MAX) bright_acc++;
      col_acc = sum_add_sat(col_acc, px.pixel_col);
      row_acc = sum_add_sat(row_acc, px.pixel_row);
    end
    if (px.frame_end) begin
      if (bright_acc == '0) begin
        res.centroid_col_q8 = '0;
        res.centroid_row_q8 = '0;
        res.bright_count    = '0;
        res.none_found      = 1'b1;
      end else begin
        res.centroid_col_q8 = mean_q8(col_acc, bright_acc);
        res.centroid_row_q8 = mean_q8(row_acc, bright_acc);
        res.bright_count    = bright_acc;
        res.none_found      = 1'b0;
      end
      centroid_q.push_back(res);
      bright_acc = '0;
      col_acc    = '0;
      row_acc    = '0;
    end
  endtask

  function automatic bpc_pkg::pixel_in_t make_pixel(input int inten, input int col,
                                                    input int row, input bit last);
    bpc_pkg::pixel_in_t px;
    px.intensity = inten[bpc_pkg::INTEN_W-1:0];
    px.pixel_col = col[bpc_pkg::COORD_W-1:0];
    px.pixel_row = row[bpc_pkg::COORD_W-1:0];
    px.frame_end = last;
    return px;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input bpc_pkg::pixel_in_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      in_data  = PIX_W'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (in_stall);
    account_pixel(px);
    pixels_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    in_data  = PIX_W'($urandom);
  endtask

  task automatic wait_results_drained();
    while (centroid_q.size() != 0) @(negedge clk);
  endtask

  // Only written with no frame in flight, so the divider has nothing left.
  task automatic set_threshold(input logic [bpc_pkg::INTEN_W-1:0] value);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_wr_data = bpc_pkg::INTEN_W'($urandom);
    thresh_now  = value;
  endtask

  function automatic int pick_intensity(input int mode);
    int t;
    case (mode)
      1: begin
        t = int'(thresh_now) + int'($urandom_range(2)) - 1;
        return (t < 0) ? 0 : (t > 255) ? 255 : t;
      end
      2: return $urandom_range(thresh_now);
      3: return (thresh_now == 8'd255) ? 255 : $urandom_range(255, thresh_now + 1);
      default: return $urandom_range(255);
    endcase
  endfunction

  // Most frames are raster scans of a small window; some are scattered noise
  // with frame ends falling anywhere.
  task automatic send_random_frame();
    int w, h, c0, r0, mode, n;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++)
        send_pixel(make_pixel($urandom_range(255), $urandom_range(1023),
                              $urandom_range(1023),
                              (i == n - 1) || ($urandom_range(7) == 0)));
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      if ($urandom_range(19) == 0) begin
        w = $urandom_range(16, 64);
        h = $urandom_range(4, 8);
      end
      c0   = $urandom_range(1023);
      r0   = $urandom_range(1023);
      mode = $urandom_range(5);
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          send_pixel(make_pixel(pick_intensity(mode), c0 + x, r0 + y,
                                (x == w - 1) && (y == h - 1)));
    end
  endtask

  task automatic test_default_threshold();
    // Intensity equal to the threshold is dark; one above it is bright.
    send_pixel(make_pixel(125, 5, 5, 1'b0));
    send_pixel(make_pixel(126, 0, 0, 1'b0));
    send_pixel(make_pixel(255, 1023, 1023, 1'b0));
    send_pixel(make_pixel(0, 1023, 1023, 1'b1));
    send_pixel(make_pixel(255, 1023, 1023, 1'b1));
    send_pixel(make_pixel(125, 7, 9, 1'b1));
    // Column mean of 2/3 must truncate.
    send_pixel(make_pixel(200, 0, 0, 1'b0));
    send_pixel(make_pixel(200, 1, 1, 1'b0));
    send_pixel(make_pixel(200, 1, 2, 1'b1));
  endtask

  task automatic test_threshold_extremes();
    set_threshold(8'd0);
    send_pixel(make_pixel(0, 3, 4, 1'b0));
    send_pixel(make_pixel(1, 3, 4, 1'b1));
    set_threshold(8'd255);
    send_pixel(make_pixel(255, 100, 200, 1'b0));
    send_pixel(make_pixel(255, 1023, 0, 1'b1));
  endtask

  task automatic test_random_frames(input int gap_pct, input int stall_pct,
                                    input int n_pixels);
    int stop_at;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    stop_at        = pixels_sent + n_pixels;
    set_threshold(bpc_pkg::INTEN_W'($urandom_range(255)));
    while (pixels_sent < stop_at - n_pixels / 2) send_random_frame();
    // Let every frame drain before retuning the threshold mid-stream.
    set_threshold(bpc_pkg::INTEN_W'($urandom_range(255)));
    while (pixels_sent < stop_at) send_random_frame();
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (centroid_q.size() == 0) begin
        $error("result transfer with none expected: %p", out_data);
        error_count++;
      end else begin
        oldest_res = centroid_q.pop_front();
        if (out_data.centroid_col_q8 !== oldest_res.centroid_col_q8) begin
          $error("centroid_col_q8 expected %0d actual %0d",
                 oldest_res.centroid_col_q8, out_data.centroid_col_q8);
          error_count++;
        end
        if (out_data.centroid_row_q8 !== oldest_res.centroid_row_q8) begin
          $error("centroid_row_q8 expected %0d actual %0d",
                 oldest_res.centroid_row_q8, out_data.centroid_row_q8);
          error_count++;
        end
        if (out_data.bright_count !== oldest_res.bright_count) begin
          $error("bright_count expected %0d actual %0d",
                 oldest_res.bright_count, out_data.bright_count);
          error_count++;
        end
        if (out_data.none_found !== oldest_res.none_found) begin
          $error("none_found expected %0d actual %0d",
                 oldest_res.none_found, out_data.none_found);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    pixels_sent    = 0;
    cycle_count    = 0;
    thresh_now     = bpc_pkg::THRESH_RESET;
    bright_acc     = '0;
    col_acc        = '0;
    row_acc        = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_default_threshold();
    test_threshold_extremes();
    test_random_frames(21, 57, 600);
    test_random_frames(57, 21, 600);
    test_random_frames(0, 0, 600);

    wait_results_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (centroid_q.size() != 0) begin
      $error("%0d frame results never arrived", centroid_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[bright_pixel_centroid] OK");
    end else begin
      $display("[bright_pixel_centroid] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bpc_pkg.sv
rtl/bpc_front.sv
rtl/bpc_queue.sv
rtl/bpc_back.sv
rtl/bright_pixel_centroid.sv
verif/bright_pixel_centroid_tb.sv
